// ===== design/nspc_pkg.sv =====
package nspc_pkg;

    localparam int MAX_SITES  = 256;
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 8;
    localparam int POS_BITS   = COORD_BITS + FRAC_BITS;
    localparam int IDX_BITS   = 8;
    localparam int CNT_BITS   = 9;
    localparam int COLOR_BITS = 24;
    localparam int SQ_BITS    = 2 * POS_BITS;
    localparam int DIST_BITS  = 41;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                    op;
        logic [IDX_BITS-1:0]    site_index;
        logic [POS_BITS-1:0]    site_x;
        logic [POS_BITS-1:0]    site_y;
        logic [COLOR_BITS-1:0]  site_color;
        logic [COORD_BITS-1:0]  pixel_x;
        logic [COORD_BITS-1:0]  pixel_y;
    } in_item_t;

    typedef struct packed
    {
        logic [IDX_BITS-1:0]    nearest_index;
        logic [COLOR_BITS-1:0]  nearest_color;
        logic [DIST_BITS-1:0]   nearest_distance;
    } out_item_t;

    typedef struct packed
    {
        logic [POS_BITS-1:0]    x;
        logic [POS_BITS-1:0]    y;
        logic [COLOR_BITS-1:0]  color;
    } site_entry_t;

endpackage

// ===== design/nearest_site_pixel_classifier.sv =====
// Nearest-site classifier. A load item (op = load) writes one site entry;
// busy stays low. A query item sweeps sites 0 .. site_count-1 (site_count
// clamped to 1 .. 256) through one distance-and-compare pipeline, one site
// per cycle, reading the site table once per cycle. busy is high while the
// sweep and the pipeline drain run, and the result is strobed on done for
// exactly one cycle after the last site has passed the compare. The receiver
// cannot stall: done must be sampled when it rises. Ties go to the lower index.
// Querying a site never loaded since reset gives undefined result fields.
module nearest_site_pixel_classifier
    import nspc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  in_item_t             cmd,
    output logic                 done,
    output out_item_t            result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CNT_BITS-1:0]  cfg_data
);

    typedef enum logic [2:0]
    {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_SITES);

    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    site_count_reg;
    logic [POS_BITS-1:0]    px_reg, py_reg;
    logic [IDX_BITS-1:0]    rd_addr_reg, last_reg, last_next;

    // site table
    site_entry_t            site_mem [MAX_SITES];
    site_entry_t            rd_data_reg;

    // pipeline stage 1: table read
    logic                   v1_reg, last1_reg;
    logic [IDX_BITS-1:0]    idx1_reg;
    // stage 2: absolute differences
    logic                   v2_reg, last2_reg;
    logic [IDX_BITS-1:0]    idx2_reg;
    logic [COLOR_BITS-1:0]  color2_reg;
    logic [POS_BITS-1:0]    dx_reg, dy_reg, dx_next, dy_next;
    // stage 3: squares
    logic                   v3_reg, last3_reg;
    logic [IDX_BITS-1:0]    idx3_reg;
    logic [COLOR_BITS-1:0]  color3_reg;
    logic [SQ_BITS-1:0]     sqx_reg, sqy_reg, sqx_next, sqy_next;
    // running best
    logic [IDX_BITS-1:0]    best_idx_reg, best_idx_next;
    logic [COLOR_BITS-1:0]  best_color_reg, best_color_next;
    logic [DIST_BITS-1:0]   best_dist_reg, best_dist_next;
    logic [DIST_BITS-1:0]   cand_dist;
    logic                   take;

    logic                   done_reg;
    out_item_t              result_reg;

    logic                   accept, load_we, query_go, issue;
    logic [CNT_BITS-1:0]    cnt_m1;

    assign accept   = start && (state_reg == S_IDLE);
    assign load_we  = accept && (cmd.op == OP_LOAD);
    assign query_go = accept && (cmd.op == OP_QUERY);
    assign issue    = (state_reg == S_SCAN);

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;

    // clamp the site count to 1 .. MAX_SITES and take the last index
    always_comb
    begin
        cnt_m1 = site_count_reg - CNT_BITS'(1);
        priority if (site_count_reg == '0)
            last_next = '0;
        else if (site_count_reg > MAX_CNT)
            last_next = IDX_BITS'(MAX_SITES - 1);
        else
            last_next = cnt_m1[IDX_BITS-1:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (query_go)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (rd_addr_reg == last_reg)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (v3_reg && last3_reg)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            site_count_reg <= CNT_BITS'(1);
            rd_addr_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                site_count_reg <= cfg_data;
            // advance the read address during the sweep
            if (query_go)
                rd_addr_reg <= '0;
            else if (issue)
                rd_addr_reg <= rd_addr_reg + IDX_BITS'(1);
        end
    end

    // latch the query position and sweep length
    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            px_reg   <= {cmd.pixel_x, FRAC_BITS'(0)};
            py_reg   <= {cmd.pixel_y, FRAC_BITS'(0)};
            last_reg <= last_next;
        end
    end

    // site table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (load_we)
            site_mem[cmd.site_index] <= '{x: cmd.site_x, y: cmd.site_y, color: cmd.site_color};
        rd_data_reg <= site_mem[rd_addr_reg];
    end

    // datapath arithmetic
    always_comb
    begin
        dx_next  = (rd_data_reg.x > px_reg) ? (rd_data_reg.x - px_reg) : (px_reg - rd_data_reg.x);
        dy_next  = (rd_data_reg.y > py_reg) ? (rd_data_reg.y - py_reg) : (py_reg - rd_data_reg.y);
        sqx_next = SQ_BITS'(dx_reg) * SQ_BITS'(dx_reg);
        sqy_next = SQ_BITS'(dy_reg) * SQ_BITS'(dy_reg);
        // two squares below 2^40 never reach the top of the 41-bit range
        cand_dist = DIST_BITS'(sqx_reg) + DIST_BITS'(sqy_reg);
        take      = (idx3_reg == '0) || (cand_dist < best_dist_reg);
        if (take)
        begin
            best_idx_next   = idx3_reg;
            best_color_next = color3_reg;
            best_dist_next  = cand_dist;
        end
        else
        begin
            best_idx_next   = best_idx_reg;
            best_color_next = best_color_reg;
            best_dist_next  = best_dist_reg;
        end
    end

    // stage valid flags and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= issue;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg && last3_reg;
        end
    end

    // stage payload and running best
    always_ff @(posedge clk)
    begin
        idx1_reg   <= rd_addr_reg;
        last1_reg  <= (rd_addr_reg == last_reg);

        idx2_reg   <= idx1_reg;
        last2_reg  <= last1_reg;
        color2_reg <= rd_data_reg.color;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;

        idx3_reg   <= idx2_reg;
        last3_reg  <= last2_reg;
        color3_reg <= color2_reg;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;

        if (v3_reg)
        begin
            best_idx_reg   <= best_idx_next;
            best_color_reg <= best_color_next;
            best_dist_reg  <= best_dist_next;
        end

        // hold the result of the last site
        if (v3_reg && last3_reg)
            result_reg <= '{nearest_index: best_idx_next,
                            nearest_color: best_color_next,
                            nearest_distance: best_dist_next};
    end

endmodule
